// ----- sv/sbus_frame_decoder_macros.svh -----
// ----------------------------------------------------------------------------
// SBUS frame decoder assertion macros
// Immediate-cycle and next-cycle implication checks on clock and reset.
// ----------------------------------------------------------------------------
`ifndef SBUS_FRAME_DECODER_MACROS_SVH
`define SBUS_FRAME_DECODER_MACROS_SVH
`ifndef SYNTHESIS
`define SFD_ASSERT_NOW(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("sbus frame decoder check failed");
`define SFD_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("sbus frame decoder check failed");
`else
`define SFD_ASSERT_NOW(name, pre, post)
`define SFD_ASSERT_NEXT(name, pre, post)
`endif
`endif

// ----- sv/sfd_pkg.sv -----
// ----------------------------------------------------------------------------
// SBUS frame decoder package
// Frame layout constants and the control bundle from the byte collector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfd_pkg;

   localparam int FRAME_BYTES   = 25;
   localparam int CHANNEL_COUNT = 16;
   localparam int CHAN_BITS     = 11;
   localparam int COUNT_W       = 5;
   localparam int CHAN_IDX_W    = 4;
   localparam int FLAG_W        = 4;
   localparam int PAYLOAD_BITS  = CHANNEL_COUNT * CHAN_BITS;

   localparam logic [7:0] START_BYTE = 8'h0F;

   localparam logic [COUNT_W-1:0] FIRST_PAYLOAD_POS = 5'd1;
   localparam logic [COUNT_W-1:0] LAST_PAYLOAD_POS  = 5'd22;
   localparam logic [COUNT_W-1:0] FLAGS_POS         = 5'd23;
   localparam logic [COUNT_W-1:0] END_POS           = 5'd24;

   localparam logic [CHAN_IDX_W-1:0] LAST_CHANNEL = 4'(CHANNEL_COUNT - 1);

   typedef struct packed {
      logic shift_in;    // payload byte accepted
      logic take_flags;  // flags byte accepted
      logic frame_ok;    // end byte accepted and valid
   } ctl_type;

   function automatic logic end_byte_ok(input logic [7:0] b);
      end_byte_ok = (b == 8'h00) || (b == 8'h04) || (b == 8'h14) ||
                    (b == 8'h24) || (b == 8'h34);
   endfunction

endpackage

// ----- sv/sfd_collect.sv -----
// ----------------------------------------------------------------------------
// SBUS byte collector
// Tracks the byte position within a frame and flags payload, flags and end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_collect (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   output sfd_pkg::ctl_type   ctl
);

   logic [sfd_pkg::COUNT_W-1:0] count_ff;
   logic [sfd_pkg::COUNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (accept) begin
         if (count_ff == '0) begin
            // drop anything but the start byte while idle
            if (rx_byte == sfd_pkg::START_BYTE) begin
               count_in = sfd_pkg::FIRST_PAYLOAD_POS;
            end
         end else if (count_ff == sfd_pkg::END_POS) begin
            count_in = '0;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_comb begin
      ctl.shift_in   = accept && (count_ff >= sfd_pkg::FIRST_PAYLOAD_POS) &&
                       (count_ff <= sfd_pkg::LAST_PAYLOAD_POS);
      ctl.take_flags = accept && (count_ff == sfd_pkg::FLAGS_POS);
      ctl.frame_ok   = accept && (count_ff == sfd_pkg::END_POS) &&
                       sfd_pkg::end_byte_ok(rx_byte);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/sfd_unpack.sv -----
// ----------------------------------------------------------------------------
// SBUS payload unpacker
// Shifts payload bytes in, then shifts one 11-bit channel out per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfd_unpack (
   input  logic                           clock,
   input  sfd_pkg::ctl_type               ctl,
   input  logic                           step,
   input  logic [7:0]                     rx_byte,
   input  logic [63:0]                    rx_time_us,
   output logic [sfd_pkg::CHAN_BITS-1:0]  chan_value,
   output logic [sfd_pkg::FLAG_W-1:0]     flags,
   output logic [63:0]                    frame_time_us
);

   localparam int PB = sfd_pkg::PAYLOAD_BITS;
   localparam int CB = sfd_pkg::CHAN_BITS;

   logic [PB-1:0]                  payload_ff;
   logic [PB-1:0]                  payload_in;
   logic [sfd_pkg::FLAG_W-1:0]     flags_ff;
   logic [63:0]                    time_ff;

   always_comb begin
      payload_in = payload_ff;
      if (ctl.shift_in) begin
         // first payload byte ends up in the low bits after the last shift
         payload_in = {rx_byte, payload_ff[PB-1:8]};
      end else if (step) begin
         payload_in = {{CB{1'b0}}, payload_ff[PB-1:CB]};
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
      if (ctl.take_flags) begin
         flags_ff <= rx_byte[sfd_pkg::FLAG_W-1:0];
      end
      if (ctl.frame_ok) begin
         time_ff <= rx_time_us;
      end
   end

   assign chan_value    = payload_ff[CB-1:0];
   assign flags         = flags_ff;
   assign frame_time_us = time_ff;

endmodule

// ----- sv/sfd_seq.sv -----
// ----------------------------------------------------------------------------
// SBUS channel sequencer
// Steps through the sixteen channels and holds each in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sbus_frame_decoder_macros.svh"

module sfd_seq (
   input  logic                            clock,
   input  logic                            reset,
   input  sfd_pkg::ctl_type                ctl,
   input  logic [sfd_pkg::CHAN_BITS-1:0]   chan_value,
   input  logic [sfd_pkg::FLAG_W-1:0]      flags,
   input  logic [63:0]                     frame_time_us,
   output logic                            busy,
   output logic                            step,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sfd_pkg::CHAN_IDX_W-1:0]  rsp_channel_index,
   output logic [sfd_pkg::CHAN_BITS-1:0]   rsp_channel_value,
   output logic                            rsp_digital_a,
   output logic                            rsp_digital_b,
   output logic                            rsp_lost_flag,
   output logic                            rsp_failsafe_flag,
   output logic [63:0]                     rsp_frame_time_us,
   output logic                            rsp_last_channel
);

   logic                             busy_ff;
   logic                             busy_in;
   logic [sfd_pkg::CHAN_IDX_W-1:0]   chan_ff;
   logic [sfd_pkg::CHAN_IDX_W-1:0]   chan_in;
   logic                             valid_ff;
   logic                             valid_in;
   logic [sfd_pkg::CHAN_IDX_W-1:0]   index_ff;
   logic [sfd_pkg::CHAN_BITS-1:0]    value_ff;
   logic [sfd_pkg::FLAG_W-1:0]       flags_ff;
   logic [63:0]                      time_ff;
   logic                             last_ff;
   logic                             load;
   logic                             at_last;

   // while busy, load the output register whenever it is empty or being drained
   assign load    = busy_ff && (!valid_ff || rsp_ready);
   assign step    = load;
   assign at_last = (chan_ff == sfd_pkg::LAST_CHANNEL);

   always_comb begin
      busy_in  = busy_ff;
      chan_in  = chan_ff;
      valid_in = valid_ff;
      if (ctl.frame_ok) begin
         busy_in = 1'b1;
         chan_in = '0;
      end
      if (load) begin
         valid_in = 1'b1;
         chan_in  = chan_ff + 1'b1;
         if (at_last) begin
            busy_in = 1'b0;
         end
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         chan_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         chan_ff  <= chan_in;
         valid_ff <= valid_in;
      end
      if (load) begin
         index_ff <= chan_ff;
         value_ff <= chan_value;
         flags_ff <= flags;
         time_ff  <= frame_time_us;
         last_ff  <= at_last;
      end
   end

   assign busy              = busy_ff;
   assign rsp_valid         = valid_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_channel_value = value_ff;
   assign rsp_digital_a     = flags_ff[0];
   assign rsp_digital_b     = flags_ff[1];
   assign rsp_lost_flag     = flags_ff[2];
   assign rsp_failsafe_flag = flags_ff[3];
   assign rsp_frame_time_us = time_ff;
   assign rsp_last_channel  = last_ff;

   `SFD_ASSERT_NOW(a_no_frame_while_busy, ctl.frame_ok, !busy_ff)
   `SFD_ASSERT_NEXT(a_frame_starts_at_zero, ctl.frame_ok, busy_ff && (chan_ff == '0))
   `SFD_ASSERT_NEXT(a_last_ends_burst, load && at_last, !busy_ff && valid_ff && last_ff)
   `SFD_ASSERT_NEXT(a_inner_not_last, load && !at_last, busy_ff && !last_ff)

endmodule

// ----- sv/sbus_frame_decoder.sv -----
// ----------------------------------------------------------------------------
// SBUS frame decoder
// Bytes are taken one per cycle while a frame is collected and req_ready is high;
// they yield no result. A valid end byte sets busy, then loads channel 0 into the
// output register; then one channel per cycle while rsp_ready is high, 16 in all.
// req_ready is low from the end byte until the last channel is loaded.
// Synchronous reset clears the byte position, the sequencer and rsp_valid.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sbus_frame_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_rx_byte,
   input  logic [63:0]  req_rx_time_us,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [3:0]   rsp_channel_index,
   output logic [10:0]  rsp_channel_value,
   output logic         rsp_digital_a,
   output logic         rsp_digital_b,
   output logic         rsp_lost_flag,
   output logic         rsp_failsafe_flag,
   output logic [63:0]  rsp_frame_time_us,
   output logic         rsp_last_channel
);

   sfd_pkg::ctl_type                 ctl;
   logic                             accept;
   logic                             busy;
   logic                             step;
   logic [sfd_pkg::CHAN_BITS-1:0]    chan_value;
   logic [sfd_pkg::FLAG_W-1:0]       flags;
   logic [63:0]                      frame_time_us;

   // hold off new bytes while a channel burst is in flight
   assign req_ready = !busy;
   assign accept    = req_valid && req_ready;

   sfd_collect u_collect (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .ctl     (ctl)
   );

   sfd_unpack u_unpack (
      .clock         (clock),
      .ctl           (ctl),
      .step          (step),
      .rx_byte       (req_rx_byte),
      .rx_time_us    (req_rx_time_us),
      .chan_value    (chan_value),
      .flags         (flags),
      .frame_time_us (frame_time_us)
   );

   sfd_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .ctl               (ctl),
      .chan_value        (chan_value),
      .flags             (flags),
      .frame_time_us     (frame_time_us),
      .busy              (busy),
      .step              (step),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_channel_index (rsp_channel_index),
      .rsp_channel_value (rsp_channel_value),
      .rsp_digital_a     (rsp_digital_a),
      .rsp_digital_b     (rsp_digital_b),
      .rsp_lost_flag     (rsp_lost_flag),
      .rsp_failsafe_flag (rsp_failsafe_flag),
      .rsp_frame_time_us (rsp_frame_time_us),
      .rsp_last_channel  (rsp_last_channel)
   );

endmodule
